@@ hdl/liquidity_window_factor_defines.svh @@
// Assertion macros for the liquidity window factor block
`ifndef LIQUIDITY_WINDOW_FACTOR_DEFINES_SVH
`define LIQUIDITY_WINDOW_FACTOR_DEFINES_SVH
`define LWF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("lwf check failed");
`define LWF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("lwf check failed");
`endif

@@ hdl/lwf_pkg.sv @@
// Shared types and constants for the liquidity window factor block
package lwf_pkg;
	localparam int MAX_SAMPLES = 4096;
	localparam int COUNT_CAP = (MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191;
	localparam logic [12:0] COUNT_CAP_V = 13'(COUNT_CAP);
	localparam logic [1:0] MODE_TURNOVER = 2'd0;
	localparam logic [1:0] MODE_VOLUME = 2'd1;
	localparam logic [1:0] MODE_AMIHUD = 2'd2;
	localparam logic [1:0] MODE_AMPLITUDE = 2'd3;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL0, ST_MUL1, ST_TERM, ST_TERM_ADD, ST_FIN, ST_FDIV, ST_FOUT, ST_OUT
	} lwf_state_t;

	typedef struct packed {
		logic load;
		logic mul0;
		logic mul1;
		logic term_start;
		logic term_add;
		logic plain_add;
		logic commit;
		logic fdiv_start;
		logic fout;
		logic win_clear;
	} lwf_cmd_t;

	typedef struct packed {
		logic counted;
		logic amihud_term;
		logic last;
		logic div_done;
		logic mode_amihud;
	} lwf_sts_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
		return s;
	endfunction

	function automatic logic [63:0] sat_neg(input logic [63:0] a);
		return (a == S64_MIN) ? S64_MAX : (~a + 64'd1);
	endfunction
endpackage

@@ hdl/lwf_ctrl.sv @@
// Controller state machine sequencing one request through the datapath
module lwf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  lwf_pkg::lwf_sts_t sts,
	output lwf_pkg::lwf_cmd_t cmd
);
	import lwf_pkg::*;
	lwf_state_t state_q, state_d;
	logic ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		ov_d = ov_q && !out_ready;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MUL0;
				end
			end
			ST_MUL0: begin
				if (!sts.counted) state_d = ST_FIN;
				else if (sts.amihud_term) begin
					cmd.mul0 = 1'b1;
					state_d = ST_MUL1;
				end else begin
					cmd.plain_add = !sts.mode_amihud;
					cmd.commit = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = ST_TERM;
			end
			ST_TERM: begin
				cmd.term_start = 1'b1;
				state_d = ST_TERM_ADD;
			end
			ST_TERM_ADD: begin
				if (sts.div_done) begin
					cmd.term_add = 1'b1;
					cmd.commit = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.last) begin
					cmd.fdiv_start = 1'b1;
					state_d = ST_FDIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FDIV: begin
				if (sts.div_done) state_d = ST_FOUT;
			end
			ST_FOUT: begin
				if (!ov_q || out_ready) begin
					cmd.fout = 1'b1;
					cmd.win_clear = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

@@ hdl/lwf_div.sv @@
// Shared radix-2 divider: 128-bit dividend by 72-bit divisor, one bit per cycle
module lwf_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [71:0]  den,
	output logic         done,
	output logic [127:0] quo
);
	logic [127:0] q_q;
	logic [72:0]  r_q;
	logic [71:0]  d_q;
	logic [7:0]   cnt_q;
	logic         busy_q;
	logic [72:0]  sh;
	logic         ge;

	assign sh = {r_q[71:0], q_q[127]};
	assign ge = sh >= {1'b0, d_q};
	assign done = !busy_q;
	assign quo = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 8'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 8'd1;
			if (cnt_q == 8'd127) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			r_q <= ge ? (sh - {1'b0, d_q}) : sh;
			q_q <= {q_q[126:0], ge};
		end
	end
endmodule

@@ hdl/lwf_dp.sv @@
// Datapath: window state, Amihud term product, shared divider and result registers
module lwf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  lwf_pkg::lwf_cmd_t cmd,
	output lwf_pkg::lwf_sts_t sts,
	input  logic [1:0]        metric_mode,
	input  logic [47:0]       metric_sample,
	input  logic [31:0]       close_price,
	input  logic [39:0]       traded_volume,
	input  logic              last_sample,
	output logic [63:0]       factor_value,
	output logic              factor_valid,
	output logic [12:0]       samples_seen
);
	import lwf_pkg::*;
	logic [63:0] sum_q;
	logic [12:0] cnt_q;
	logic [31:0] prev_q;
	logic        havep_q;
	logic [47:0] smp_q;
	logic [31:0] cls_q;
	logic [39:0] vol_q;
	logic        last_q, amh_q, neg_q, fvalid_q;
	logic [71:0] den_q;
	logic [63:0] plo_q;
	logic [47:0] phi;
	logic [31:0] p_eff;
	logic [31:0] diff;
	logic [127:0] dnum;
	logic [71:0]  dden;
	logic         dstart, ddone;
	logic [127:0] dquo;
	logic [63:0]  term, abs_sum, qv, fq;
	logic [12:0]  dcnt;
	logic         sum_neg_q;

	assign p_eff = (prev_q == 32'd0) ? 32'd1 : prev_q;
	assign phi = {16'd0, p_eff} * {32'd0, vol_q[39:24]};
	assign diff = (cls_q >= prev_q) ? (cls_q - prev_q) : (prev_q - cls_q);
	assign term = (dquo[127:63] != '0) ? S64_MAX : dquo[63:0];
	assign abs_sum = sum_q[63] ? (~sum_q + 64'd1) : sum_q;
	assign dcnt = amh_q ? (cnt_q - 13'd1) : cnt_q;

	always_comb begin
		dstart = cmd.term_start || cmd.fdiv_start;
		if (cmd.term_start) begin
			dnum = {36'd0, diff, 60'd0};
			dden = den_q;
		end else begin
			dnum = {64'd0, abs_sum};
			dden = {59'd0, (dcnt == 13'd0) ? 13'd1 : dcnt};
		end
	end

	lwf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	assign sts.counted = cnt_q < COUNT_CAP_V;
	assign sts.amihud_term = amh_q && havep_q;
	assign sts.last = last_q;
	assign sts.div_done = ddone && !dstart;
	assign sts.mode_amihud = amh_q;

	assign qv = sum_neg_q ? (~dquo[63:0] + 64'd1) : dquo[63:0];
	assign fq = neg_q ? sat_neg(qv) : qv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			prev_q <= '0;
			havep_q <= 1'b0;
		end else begin
			if (cmd.plain_add)
				sum_q <= sat_add(sum_q, {{16{smp_q[47]}}, smp_q});
			else if (cmd.term_add)
				sum_q <= sat_add(sum_q, term);
			if (cmd.commit) begin
				prev_q <= cls_q;
				havep_q <= 1'b1;
				cnt_q <= cnt_q + 13'd1;
			end
			if (cmd.win_clear) begin
				sum_q <= '0;
				cnt_q <= '0;
				prev_q <= '0;
				havep_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_q <= metric_sample;
			cls_q <= close_price;
			vol_q <= (traded_volume == 40'd0) ? 40'd1 : traded_volume;
			last_q <= last_sample;
			amh_q <= (metric_mode == MODE_AMIHUD);
		end
		if (cmd.mul0) plo_q <= {32'd0, p_eff} * {40'd0, vol_q[23:0]};
		if (cmd.mul1) den_q <= {8'd0, plo_q} + ({24'd0, phi} << 24);
		if (cmd.fdiv_start) begin
			neg_q <= amh_q || (metric_mode == MODE_AMPLITUDE);
			sum_neg_q <= sum_q[63];
			fvalid_q <= amh_q ? (cnt_q >= 13'd2) : (cnt_q >= 13'd1);
		end
		if (cmd.fout) begin
			factor_value <= fvalid_q ? fq : 64'd0;
			factor_valid <= fvalid_q;
			samples_seen <= cnt_q;
		end
	end
endmodule

@@ hdl/liquidity_window_factor.sv @@
// Top level of the liquidity window factor block
// A request in mean modes, and in Amihud mode for the first sample of a window, passes
// through IDLE, MUL0 and FIN; each later Amihud sample also passes MUL1, TERM and
// TERM_ADD, where it waits for the shared divider. A closing request adds FDIV, the division
// by the sample count, and FOUT, which loads the output register. A new request is taken
// while a result waits; a closing request holds in FOUT until the output register is free.
module liquidity_window_factor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [47:0] metric_sample,
	input  logic [31:0] close_price,
	input  logic [39:0] traded_volume,
	input  logic        last_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] factor_value,
	output logic        factor_valid,
	output logic [12:0] samples_seen
);
	import lwf_pkg::*;
	logic [1:0] mode_q;
	lwf_cmd_t cmd;
	lwf_sts_t sts;

	assign pready = 1'b1;
	assign prdata = {30'd0, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_TURNOVER;
		else if (psel && penable && pwrite && paddr == 1'b0) mode_q <= pwdata[1:0];
	end

	lwf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	lwf_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .metric_mode(mode_q),
		.metric_sample(metric_sample), .close_price(close_price),
		.traded_volume(traded_volume), .last_sample(last_sample),
		.factor_value(factor_value), .factor_valid(factor_valid),
		.samples_seen(samples_seen)
	);
endmodule

@@ hdl/lwf_checker.sv @@
// Port-level checker for the liquidity window factor block, with its bind
`include "liquidity_window_factor_defines.svh"
module lwf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        factor_valid,
	input logic [63:0] factor_value,
	input logic [12:0] samples_seen
);
	`LWF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(factor_value))
	`LWF_ASSERT_IMPL(a_inval_zero, clk, arst_n, out_valid && !factor_valid, factor_value == 64'd0)
	`LWF_ASSERT_IMPL(a_valid_count, clk, arst_n, out_valid && factor_valid, samples_seen != 13'd0)
	`LWF_ASSERT_NEXT(a_no_back, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind liquidity_window_factor lwf_checker u_lwf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .factor_valid(factor_valid),
	.factor_value(factor_value), .samples_seen(samples_seen)
);
